[src/fca_pkg.sv]
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types, constants and the CRC-16 byte fold for the frame CRC appender.
// ----------------------------------------------------------------------------
package fca_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_CRC_LO = 2'd1,
        KIND_CRC_HI = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [15:0] crc;
    } entry_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
        logic [7:0] t;
        t = crc[15:8] ^ data;
        t = t ^ {4'h0, t[7:4]};
        return {crc[7:0], 8'h00} ^ {t[3:0], 12'h000} ^ {3'b000, t, 5'b00000}
               ^ {8'h00, t};
    endfunction

endpackage

[src/fca_front.sv]
// ----------------------------------------------------------------------------
// fca_front
// Accepts frame bytes, folds them into the running CRC and queues each byte
// with its frame-end mark and the CRC that covers it.
// ----------------------------------------------------------------------------
module fca_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frame_valid,
    output logic              frame_stall,
    input  logic [7:0]        frame_byte,
    input  logic              last_byte,
    input  logic              q_full,
    output logic              q_push,
    output fca_pkg::entry_t   q_entry
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_fold_val;

    assign frame_stall  = q_full;
    assign q_push       = frame_valid && !q_full;
    assign crc_fold_val = fca_pkg::crc_fold(crc_reg, frame_byte);

    always_comb
    begin
        q_entry.data = frame_byte;
        q_entry.last = last_byte;
        q_entry.crc  = crc_fold_val;
        crc_next     = crc_reg;
        if (q_push)
        begin
            crc_next = last_byte ? fca_pkg::CRC_SEED : crc_fold_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= fca_pkg::CRC_SEED;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

endmodule

[src/fca_queue.sv]
// ----------------------------------------------------------------------------
// fca_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module fca_queue
#(
    parameter int unsigned DEPTH = fca_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fca_pkg::entry_t   push_entry,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output fca_pkg::entry_t   head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    fca_pkg::entry_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/fca_back.sv]
// ----------------------------------------------------------------------------
// fca_back
// Takes queued bytes into the output register and expands a frame-end byte
// into the byte, the CRC low byte and the CRC high byte.
// ----------------------------------------------------------------------------
module fca_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  fca_pkg::entry_t   q_head,
    output logic              q_pop,
    output logic              tx_valid,
    input  logic              tx_stall,
    output logic [7:0]        out_byte,
    output logic [1:0]        byte_kind,
    output logic              run_end
);

    typedef enum logic [1:0] {
        ST_EMPTY,
        ST_DATA,
        ST_CRC_LO,
        ST_CRC_HI
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    fca_pkg::entry_t hold_reg;
    fca_pkg::entry_t hold_next;
    logic            done;

    always_comb
    begin
        case (state_reg)
            ST_DATA:
            begin
                out_byte  = hold_reg.data;
                byte_kind = fca_pkg::KIND_DATA;
                run_end   = !hold_reg.last;
            end
            ST_CRC_LO:
            begin
                out_byte  = hold_reg.crc[7:0];
                byte_kind = fca_pkg::KIND_CRC_LO;
                run_end   = 1'b0;
            end
            ST_CRC_HI:
            begin
                out_byte  = hold_reg.crc[15:8];
                byte_kind = fca_pkg::KIND_CRC_HI;
                run_end   = 1'b1;
            end
            default:
            begin
                out_byte  = hold_reg.data;
                byte_kind = fca_pkg::KIND_DATA;
                run_end   = 1'b0;
            end
        endcase
    end

    assign tx_valid = (state_reg != ST_EMPTY);
    assign done     = (state_reg == ST_EMPTY) || (!tx_stall && run_end);
    assign q_pop    = done && !q_empty;

    always_comb
    begin
        state_next = state_reg;
        hold_next  = hold_reg;
        if (q_pop)
        begin
            state_next = ST_DATA;
            hold_next  = q_head;
        end
        else if (done)
        begin
            state_next = ST_EMPTY;
        end
        else if (!tx_stall)
        begin
            case (state_reg)
                ST_DATA:   state_next = ST_CRC_LO;
                ST_CRC_LO: state_next = ST_CRC_HI;
                default:   state_next = ST_EMPTY;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
            hold_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

[src/frame_crc_appender.sv]
// ----------------------------------------------------------------------------
// frame_crc_appender
// Passes frame bytes through and appends a CRC-16 (poly 0x1021, init 0xFFFF,
// no reflection, no final XOR) after each byte marked last_byte, low byte
// first. Every byte comes out tagged in byte_kind, and run_end marks the final
// output of each input byte. One frame byte is taken per cycle unless the queue
// is full; a marked byte holds the single output register for its three output
// bytes, so the frame side stalls only once the QUEUE_DEPTH-entry queue from
// the CRC stage to the output stage fills. Bytes are queued, then registered.
// ----------------------------------------------------------------------------
module frame_crc_appender
#(
    parameter int unsigned QUEUE_DEPTH = fca_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_stall,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    output logic        tx_valid,
    input  logic        tx_stall,
    output logic [7:0]  out_byte,
    output logic [1:0]  byte_kind,
    output logic        run_end
);

    fca_pkg::entry_t push_entry;
    fca_pkg::entry_t head_entry;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;

    fca_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_byte  (frame_byte),
        .last_byte   (last_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    fca_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (head_entry)
    );

    fca_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (head_entry),
        .q_pop     (q_pop),
        .tx_valid  (tx_valid),
        .tx_stall  (tx_stall),
        .out_byte  (out_byte),
        .byte_kind (byte_kind),
        .run_end   (run_end)
    );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for frame_crc_appender. Frames of random length go in
// with random gaps. A scoreboard folds each accepted byte into its own
// bit-serial CRC-16 and queues the expected pass-through and CRC bytes. Every
// output transfer is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [15:0] CCITT_POLY   = 16'h1021;
    localparam logic [71:0] CHECK_STRING = "123456789";
    localparam int          GAP_PCT      = 27;
    localparam int          RANDOM_ITEMS = 212;
    localparam int          HOLD_START   = 150;
    localparam int          HOLD_LEN     = 80;
    localparam int          QUIET_START  = 300;
    localparam int          QUIET_END    = 420;
    localparam int          STALL_LIMIT  = 1000;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          REPORT_MAX   = 10;

    typedef struct {
        logic [7:0]      data;
        fca_pkg::kind_t  kind;
        logic            run_end;
    } tx_byte_t;

    class crc_frame_scoreboard;
        logic [15:0] frame_crc;
        tx_byte_t    expected_tx[$];
        int          mismatches;
        int          noted;

        function new();
            frame_crc  = fca_pkg::CRC_SEED;
            mismatches = 0;
            noted      = 0;
        endfunction

        function logic [15:0] crc_ccitt_byte(logic [15:0] crc, logic [7:0] data);
            logic [15:0] r;
            int          i;
            r = crc ^ {data, 8'h00};
            for (i = 0; i < 8; i++)
                r = r[15] ? ((r << 1) ^ CCITT_POLY) : (r << 1);
            return r;
        endfunction

        function void push_tx(logic [7:0] data, fca_pkg::kind_t kind, logic run_end);
            tx_byte_t e;
            e.data    = data;
            e.kind    = kind;
            e.run_end = run_end;
            expected_tx.push_back(e);
        endfunction

        function void note_frame_byte(logic [7:0] data, logic last);
            noted++;
            frame_crc = crc_ccitt_byte(frame_crc, data);
            push_tx(data, fca_pkg::KIND_DATA, !last);
            if (last)
            begin
                push_tx(frame_crc[7:0], fca_pkg::KIND_CRC_LO, 1'b0);
                push_tx(frame_crc[15:8], fca_pkg::KIND_CRC_HI, 1'b1);
                frame_crc = fca_pkg::CRC_SEED;
            end
        endfunction

        function void check_tx(logic [7:0] data, logic [1:0] kind, logic run_end);
            tx_byte_t e;
            if (expected_tx.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected transfer byte=%h kind=%0d end=%b",
                             $time, data, kind, run_end);
                return;
            end
            e = expected_tx.pop_front();
            if (data !== e.data || kind !== e.kind || run_end !== e.run_end)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"%0t: mismatch exp byte=%h kind=%0d end=%b",
                              " got byte=%h kind=%0d end=%b"},
                             $time, e.data, e.kind, e.run_end, data, kind, run_end);
            end
        endfunction

        function int pending();
            return expected_tx.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       frame_valid = 1'b0;
    logic       frame_stall;
    logic [7:0] frame_byte  = 8'h00;
    logic       last_byte   = 1'b0;
    logic       tx_valid;
    logic       tx_stall    = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic       run_end;

    crc_frame_scoreboard sb = new();
    int n_sent      = 0;
    int rx_cycle    = 0;
    int idle_cycles = 0;

    frame_crc_appender DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_byte  (frame_byte),
        .last_byte   (last_byte),
        .tx_valid    (tx_valid),
        .tx_stall    (tx_stall),
        .out_byte    (out_byte),
        .byte_kind   (byte_kind),
        .run_end     (run_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_byte(input logic [7:0] data, input logic last, input bit gaps);
        while (gaps && $urandom_range(99) < GAP_PCT)
        begin
            frame_valid <= 1'b0;
            @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame_byte  <= data;
        last_byte   <= last;
        @(posedge clk);
        while (frame_stall)
            @(posedge clk);
        n_sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (frame_valid && !frame_stall)
                sb.note_frame_byte(frame_byte, last_byte);
            if (tx_valid && !tx_stall)
                sb.check_tx(out_byte, byte_kind, run_end);
        end
    end

    // hold off for a long stretch so the block fills and stalls its input
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
                tx_stall <= 1'b1;
            else if (rx_cycle >= QUIET_START && rx_cycle < QUIET_END)
                tx_stall <= 1'b0;
            else
                tx_stall <= ($urandom_range(99) < GAP_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !((frame_valid && !frame_stall) || (tx_valid && !tx_stall)))
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("frame_crc_appender verification failed");
                $finish;
            end
        end
        else
            idle_cycles = 0;
    end

    initial
    begin
        int i;
        int len;
        int n_rand;
        n_rand = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        for (i = 8; i >= 0; i--)
            send_byte(CHECK_STRING[i*8 +: 8], i == 0, 1'b1);
        send_byte(8'hAA, 1'b0, 1'b1);
        send_byte(8'h55, 1'b0, 1'b1);
        send_byte(8'h01, 1'b0, 1'b1);
        send_byte(8'h80, 1'b1, 1'b1);
        send_byte(8'h7F, 1'b1, 1'b0);
        send_byte(8'hFE, 1'b1, 1'b0);

        while (n_rand < RANDOM_ITEMS)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(6, 1);
            if (len > RANDOM_ITEMS - n_rand)
                len = RANDOM_ITEMS - n_rand;
            for (i = 0; i < len; i++)
            begin
                send_byte(8'($urandom_range(255)), i == len - 1,
                          !(n_rand >= 100 && n_rand < 150));
                n_rand++;
            end
        end
        frame_valid <= 1'b0;

        while (sb.noted != n_sent || sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("frame_crc_appender verification clean");
        else
            $display("frame_crc_appender verification failed");
        $finish;
    end

endmodule
